>>> sv/mtq_pkg.sv
// shared constants, codes and word types for the mutex table with wait queues
// no dependencies; imported by every module of the block
package mtq_pkg;

  localparam int MAX_SLOTS    = 16;
  localparam int MAX_WAITERS  = 8;   // a power of two: queue positions wrap in place
  localparam int PID_BITS     = 22;

  localparam int ACTION_BITS  = 3;
  localparam int ID_BITS      = 5;
  localparam int STATUS_BITS  = 2;
  localparam int SLOT_BITS    = $clog2(MAX_SLOTS);
  localparam int CREATED_BITS = $clog2(MAX_SLOTS + 1);
  localparam int WAIT_BITS    = $clog2(MAX_WAITERS);
  localparam int CNT_BITS     = $clog2(MAX_WAITERS + 1);

  localparam logic [ACTION_BITS-1:0] ACT_OPEN   = 3'd0;
  localparam logic [ACTION_BITS-1:0] ACT_CLOSE  = 3'd1;
  localparam logic [ACTION_BITS-1:0] ACT_LOCK   = 3'd2;
  localparam logic [ACTION_BITS-1:0] ACT_CHECK  = 3'd3;
  localparam logic [ACTION_BITS-1:0] ACT_UNLOCK = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_WAIT    = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_REFUSED = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [ID_BITS-1:0]     mutex_id;
    logic [PID_BITS-1:0]    process_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     granted_id;
  } resp_t;

  // controller to slot table
  typedef struct packed {
    logic                 take;
    logic                 close;
    logic                 lock;
    logic                 unlock;
    logic [SLOT_BITS-1:0] slot;
    logic [PID_BITS-1:0]  pid;
  } slot_cmd_t;

  // slot table to controller
  typedef struct packed {
    logic                 open;
    logic                 locked;
    logic                 full;
    logic [SLOT_BITS-1:0] free_slot;
    logic [PID_BITS-1:0]  owner;
  } slot_info_t;

  // controller to wait queues
  typedef struct packed {
    logic                 push;
    logic                 pop;
    logic [SLOT_BITS-1:0] slot;
    logic [WAIT_BITS-1:0] rd_offset;
    logic [PID_BITS-1:0]  pid;
  } wq_cmd_t;

  // wait queues to controller
  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic                full;
    logic [PID_BITS-1:0] rd_data;
  } wq_info_t;

endpackage

>>> sv/mtq_slot_table.sv
// slot table: open and locked marks, created count and the owner memory
// depends on mtq_pkg
module mtq_slot_table import mtq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  slot_cmd_t  cmd,
  output slot_info_t info
);

  logic [MAX_SLOTS-1:0]    open_q;
  logic [MAX_SLOTS-1:0]    locked_q;
  logic [CREATED_BITS-1:0] created;
  logic [PID_BITS-1:0]     owner_mem [MAX_SLOTS];
  logic [PID_BITS-1:0]     owner_rd;

  logic [MAX_SLOTS-1:0]    avail;
  logic                    found;
  logic [SLOT_BITS-1:0]    first;
  logic [SLOT_BITS-1:0]    free_slot;
  logic                    free_grow;
  logic                    free_full;

  // lowest created slot that is closed
  always_comb begin
    found = 1'b0;
    first = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      avail[i] = !open_q[i] && (CREATED_BITS'(i) < created);
    end
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        found = 1'b1;
        first = SLOT_BITS'(i);
      end
    end
  end

  // search result is registered; no command changes the table between the search and the use of its result
  always_ff @(posedge clk) begin
    if (rst) begin
      free_slot <= '0;
      free_grow <= 1'b1;
      free_full <= 1'b0;
    end else if (found) begin
      free_slot <= first;
      free_grow <= 1'b0;
      free_full <= 1'b0;
    end else begin
      free_slot <= created[SLOT_BITS-1:0];
      free_grow <= 1'b1;
      free_full <= (created == CREATED_BITS'(MAX_SLOTS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_q   <= '0;
      locked_q <= '0;
      created  <= '0;
    end else begin
      if (cmd.take) begin
        open_q[free_slot]   <= 1'b1;
        locked_q[free_slot] <= 1'b0;
        if (free_grow) begin
          created <= created + 1'b1;
        end
      end
      if (cmd.close) begin
        open_q[cmd.slot]   <= 1'b0;
        locked_q[cmd.slot] <= 1'b0;
      end
      if (cmd.lock) begin
        locked_q[cmd.slot] <= 1'b1;
      end
      if (cmd.unlock) begin
        locked_q[cmd.slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      owner_mem[free_slot] <= cmd.pid;
    end
    owner_rd <= owner_mem[cmd.slot];
  end

  assign info.open      = open_q[cmd.slot];
  assign info.locked    = locked_q[cmd.slot];
  assign info.full      = free_full;
  assign info.free_slot = free_slot;
  assign info.owner     = owner_rd;

endmodule

>>> sv/mtq_wait_queue.sv
// per-slot circular wait queues: one shared id memory, head and count per slot
// depends on mtq_pkg
module mtq_wait_queue import mtq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  wq_cmd_t  cmd,
  output wq_info_t info
);

  localparam int ADDR_BITS = SLOT_BITS + WAIT_BITS;

  logic [CNT_BITS-1:0]  count [MAX_SLOTS];
  logic [WAIT_BITS-1:0] head  [MAX_SLOTS];
  logic [PID_BITS-1:0]  mem   [MAX_SLOTS*MAX_WAITERS];
  logic [PID_BITS-1:0]  rd_data;

  logic [CNT_BITS-1:0]  cur_count;
  logic [WAIT_BITS-1:0] cur_head;
  logic [WAIT_BITS-1:0] tail_pos;
  logic [WAIT_BITS-1:0] rd_pos;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [ADDR_BITS-1:0] rd_addr;

  assign cur_count = count[cmd.slot];
  assign cur_head  = head[cmd.slot];
  // positions wrap around the slot's row
  assign tail_pos  = cur_head + cur_count[WAIT_BITS-1:0];
  assign rd_pos    = cur_head + cmd.rd_offset;
  assign wr_addr   = {cmd.slot, tail_pos};
  assign rd_addr   = {cmd.slot, rd_pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        count[i] <= '0;
        head[i]  <= '0;
      end
    end else if (cmd.push) begin
      count[cmd.slot] <= cur_count + 1'b1;
    end else if (cmd.pop) begin
      count[cmd.slot] <= cur_count - 1'b1;
      head[cmd.slot]  <= cur_head + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= cmd.pid;
    end
    rd_data <= mem[rd_addr];
  end

  assign info.count   = cur_count;
  assign info.full    = (cur_count == CNT_BITS'(MAX_WAITERS));
  assign info.rd_data = rd_data;

endmodule

>>> sv/mutex_table_with_wait_queues.sv
// mutex table with fifo wait queues: request decode, sequencing and result word
// depends on mtq_pkg, mtq_slot_table and mtq_wait_queue
//
// usage:
//   request channel (req_valid, req_stall, req): one word per action, carrying
//   action, mutex_id and process_id. the block takes one word at a time and
//   holds req_stall high from acceptance until that word's result is queued.
//   result channel (resp_valid, resp_stall, resp): exactly one word per request,
//   status and granted_id, in request order, from an output register.
//   open, lock, unlock and bad requests go from execute to finish; close first
//   reads the owner memory, and check scans the slot's queue of up to 8 entries,
//   one queue memory read per cycle, stopping at a match.
//   each word passes through idle, execute and finish, plus the owner read for
//   close and the scan for check; the result side can hold it in finish.
//   a new request is taken the cycle after a result is loaded, even while that
//   result is still stalled; a second result waits until the first is taken.
//   reset clears all slots, queue counts and the created count; the owner and
//   queue memories hold no defined contents until written.
module mutex_table_with_wait_queues import mtq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  req_t  req,
  output logic  resp_valid,
  input  logic  resp_stall,
  output resp_t resp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_OWNER  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]           state;
  logic [2:0]           state_next;
  req_t                 req_q;
  resp_t                res;
  resp_t                res_next;
  logic [WAIT_BITS-1:0] scan_idx;
  logic [WAIT_BITS-1:0] scan_idx_next;

  slot_cmd_t            slot_cmd;
  slot_info_t           slot_info;
  wq_cmd_t              wq_cmd;
  wq_info_t             wq_info;

  logic [SLOT_BITS-1:0] slot_idx;
  logic [ID_BITS-1:0]   id_less;
  logic                 id_ok;
  logic                 scan_last;
  logic                 out_free;

  assign id_less   = req_q.mutex_id - 1'b1;
  assign slot_idx  = id_less[SLOT_BITS-1:0];
  assign id_ok     = (req_q.mutex_id != '0) && (req_q.mutex_id <= ID_BITS'(MAX_SLOTS));
  assign scan_last = ((CNT_BITS'(scan_idx) + 1'b1) == wq_info.count);
  assign out_free  = !resp_valid || !resp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next       = state;
    res_next         = res;
    scan_idx_next    = scan_idx;
    slot_cmd         = '0;
    slot_cmd.slot    = slot_idx;
    slot_cmd.pid     = req_q.process_id;
    wq_cmd           = '0;
    wq_cmd.slot      = slot_idx;
    wq_cmd.pid       = req_q.process_id;
    wq_cmd.rd_offset = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_next.status     = ST_REFUSED;
        res_next.granted_id = '0;
        state_next          = S_FINISH;
        if (req_q.action == ACT_OPEN) begin
          if (slot_info.full) begin
            res_next.status = ST_FULL;
          end else begin
            slot_cmd.take       = 1'b1;
            res_next.status     = ST_OK;
            res_next.granted_id = ID_BITS'(slot_info.free_slot) + 1'b1;
          end
        end else if (id_ok) begin
          case (req_q.action)
            ACT_CLOSE: begin
              // owner word is read this cycle
              state_next = S_OWNER;
            end
            ACT_LOCK: begin
              if (slot_info.open) begin
                if (!slot_info.locked) begin
                  slot_cmd.lock   = 1'b1;
                  res_next.status = ST_OK;
                end else if (wq_info.full) begin
                  res_next.status = ST_FULL;
                end else begin
                  wq_cmd.push     = 1'b1;
                  res_next.status = ST_WAIT;
                end
              end
            end
            ACT_CHECK: begin
              res_next.status = ST_OK;
              if (wq_info.count != '0) begin
                scan_idx_next = '0;
                state_next    = S_SCAN;
              end
            end
            ACT_UNLOCK: begin
              if (slot_info.open && slot_info.locked) begin
                if (wq_info.count == '0) begin
                  slot_cmd.unlock = 1'b1;
                end else begin
                  wq_cmd.pop = 1'b1;
                end
                res_next.status = ST_OK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_OWNER: begin
        if (slot_info.open && !slot_info.locked && (slot_info.owner == req_q.process_id)) begin
          slot_cmd.close  = 1'b1;
          res_next.status = ST_OK;
        end
        state_next = S_FINISH;
      end
      S_SCAN: begin
        // rd_data holds the entry at scan_idx; fetch the next one meanwhile
        wq_cmd.rd_offset = scan_idx + 1'b1;
        if (wq_info.rd_data == req_q.process_id) begin
          res_next.status = ST_WAIT;
          state_next      = S_FINISH;
        end else if (scan_last) begin
          state_next = S_FINISH;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      resp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FINISH && out_free) begin
        resp_valid <= 1'b1;
      end else if (resp_valid && !resp_stall) begin
        resp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q <= req;
    end
    if (state == S_FINISH && out_free) begin
      resp <= res;
    end
    res      <= res_next;
    scan_idx <= scan_idx_next;
  end

  mtq_slot_table u_slot_table (
    .clk  (clk),
    .rst  (rst),
    .cmd  (slot_cmd),
    .info (slot_info)
  );

  mtq_wait_queue u_wait_queue (
    .clk  (clk),
    .rst  (rst),
    .cmd  (wq_cmd),
    .info (wq_info)
  );

endmodule

>>> verif/tb.sv
// testbench for mutex_table_with_wait_queues: directed and random request words
// checked against an in-bench mutex table tracker; depends on mtq_pkg and the rtl
module tb import mtq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 700;
  localparam int MAX_GAP        = 11;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_PRINTS     = 100;
  localparam int POOL_SIZE      = 6;
  localparam int ACTION_TOP     = (1 << ACTION_BITS) - 1;
  localparam int ID_TOP         = (1 << ID_BITS) - 1;

  typedef enum int {MIX, QUEUE_FILL, OPEN_BURST, DRAIN_MIX, BACKPRESSURE} round_mode_e;

  // tracks slot, owner and wait queue contents, and the result words still owed
  class mutex_tracker;
    bit                  is_open   [MAX_SLOTS];
    bit                  is_locked [MAX_SLOTS];
    bit [PID_BITS-1:0]   owner     [MAX_SLOTS];
    bit [PID_BITS-1:0]   waiters   [MAX_SLOTS][MAX_WAITERS];
    int                  n_wait    [MAX_SLOTS];
    int                  created;
    resp_t               owed_resp [$];
    int                  mismatches;

    task report(string what);
      if (mismatches < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    function void note_request(req_t r);
      resp_t o;
      int s;
      int n;
      int i;
      o.status = ST_REFUSED;
      o.granted_id = '0;
      if (r.action == ACT_OPEN) begin
        s = -1;
        for (i = 0; i < created; i++)
          if (s < 0 && !is_open[i]) s = i;
        if (s < 0 && created < MAX_SLOTS) begin
          s = created;
          created++;
        end
        if (s < 0) begin
          o.status = ST_FULL;
        end else begin
          is_open[s] = 1'b1;
          is_locked[s] = 1'b0;
          owner[s] = r.process_id;
          o.status = ST_OK;
          o.granted_id = ID_BITS'(s + 1);
        end
      end else if (r.action <= ACT_UNLOCK && r.mutex_id >= 1 && r.mutex_id <= MAX_SLOTS) begin
        s = int'(r.mutex_id) - 1;
        n = n_wait[s];
        case (r.action)
          ACT_CLOSE: begin
            if (is_open[s] && !is_locked[s] && owner[s] == r.process_id) begin
              is_open[s] = 1'b0;
              o.status = ST_OK;
            end
          end
          ACT_LOCK: begin
            if (!is_open[s]) begin
              o.status = ST_REFUSED;
            end else if (is_locked[s]) begin
              if (n >= MAX_WAITERS) begin
                o.status = ST_FULL;
              end else begin
                waiters[s][n] = r.process_id;
                n_wait[s] = n + 1;
                o.status = ST_WAIT;
              end
            end else begin
              is_locked[s] = 1'b1;
              o.status = ST_OK;
            end
          end
          ACT_CHECK: begin
            o.status = ST_OK;
            for (i = 0; i < n; i++)
              if (waiters[s][i] == r.process_id) o.status = ST_WAIT;
          end
          default: begin
            if (is_open[s] && is_locked[s]) begin
              // hand over to the queue head, or free the slot when nobody waits
              if (n == 0) begin
                is_locked[s] = 1'b0;
              end else begin
                for (i = 1; i < n; i++) waiters[s][i-1] = waiters[s][i];
                n_wait[s] = n - 1;
              end
              o.status = ST_OK;
            end
          end
        endcase
      end
      owed_resp.push_back(o);
    endfunction

    task check_resp(resp_t got);
      resp_t want;
      if (owed_resp.size() == 0) begin
        report($sformatf("result word with nothing owed: status %0d id %0d",
                         got.status, got.granted_id));
      end else begin
        want = owed_resp.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.granted_id !== want.granted_id)
          report($sformatf("granted_id %0d, want %0d", got.granted_id, want.granted_id));
      end
    endtask
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  resp_valid;
  logic  resp_stall = 1'b0;
  resp_t resp;

  mutex_tracker tracker = new();
  bit [PID_BITS-1:0] pid_pool [POOL_SIZE];
  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  bit hold_results = 1'b0;
  int items_sent = 0;
  int idle_cycles = 0;

  mutex_table_with_wait_queues u_top (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp       (resp)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) tracker.note_request(req);
      if (resp_valid && !resp_stall) tracker.check_resp(resp);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (resp_valid && !resp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stall per word, with one long hold when asked
  initial begin
    int w;
    while (rst) @(negedge clk);
    forever begin
      if (hold_results) w = HOLD_CYCLES;
      else w = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
      if (w != 0) begin
        resp_stall <= 1'b1;
        repeat (w) @(negedge clk);
        hold_results = 1'b0;
      end
      resp_stall <= 1'b0;
      do @(posedge clk); while (!(resp_valid && !resp_stall));
      @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send(input logic [ACTION_BITS-1:0] act, input logic [ID_BITS-1:0] id,
                      input logic [PID_BITS-1:0] pid);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{action: act, mutex_id: id, process_id: pid};
    do @(posedge clk); while (req_stall !== 1'b0);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (tracker.owed_resp.size() != 0);
    @(negedge clk);
  endtask

  function automatic logic [PID_BITS-1:0] pick_pid();
    if ($urandom_range(0, 9) < 7) return pid_pool[$urandom_range(0, POOL_SIZE - 1)];
    return PID_BITS'($urandom);
  endfunction

  function automatic logic [ID_BITS-1:0] pick_id();
    int top;
    top = tracker.created + 1;
    if (top > MAX_SLOTS) top = MAX_SLOTS;
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return ID_BITS'($urandom_range(MAX_SLOTS + 1, ID_TOP));
      default: return ID_BITS'($urandom_range(1, top));
    endcase
  endfunction

  function automatic bit id_in_range(logic [ID_BITS-1:0] id);
    return id >= 1 && id <= MAX_SLOTS;
  endfunction

  task automatic mix_round(input int count);
    int k;
    int r;
    logic [ACTION_BITS-1:0] act;
    logic [ID_BITS-1:0] id;
    logic [PID_BITS-1:0] pid;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      id = pick_id();
      pid = pick_pid();
      if (r < 20) act = ACT_OPEN;
      else if (r < 35) act = ACT_CLOSE;
      else if (r < 65) act = ACT_LOCK;
      else if (r < 80) act = ACT_CHECK;
      else if (r < 97) act = ACT_UNLOCK;
      else act = ACTION_BITS'($urandom_range(int'(ACT_UNLOCK) + 1, ACTION_TOP));
      // steer toward the owner or a queued pid so the matching paths get hit
      if (id_in_range(id) && $urandom_range(0, 1)) begin
        if (act == ACT_CLOSE && tracker.is_open[id-1]) pid = tracker.owner[id-1];
        if (act == ACT_CHECK && tracker.n_wait[id-1] > 0)
          pid = tracker.waiters[id-1][$urandom_range(0, tracker.n_wait[id-1] - 1)];
      end
      send(act, id, pid);
    end
  endtask

  task automatic queue_round();
    int open_ids [$];
    int i;
    int s;
    logic [ID_BITS-1:0] id;
    logic [PID_BITS-1:0] pid;
    do begin
      open_ids.delete();
      for (i = 0; i < tracker.created; i++)
        if (tracker.is_open[i]) open_ids.push_back(i);
      if (open_ids.size() == 0) send(ACT_OPEN, pick_id(), pick_pid());
    end while (open_ids.size() == 0);
    s = open_ids[$urandom_range(0, open_ids.size() - 1)];
    id = ID_BITS'(s + 1);
    // enough locks to run the queue into its full mark most of the time
    repeat ($urandom_range(7, 11)) send(ACT_LOCK, id, pick_pid());
    repeat (3) begin
      pid = pick_pid();
      if (tracker.n_wait[s] > 0 && $urandom_range(0, 1))
        pid = tracker.waiters[s][$urandom_range(0, tracker.n_wait[s] - 1)];
      send(ACT_CHECK, id, pid);
    end
    repeat ($urandom_range(0, 11)) send(ACT_UNLOCK, id, pick_pid());
    if ($urandom_range(0, 1)) send(ACT_CLOSE, id, tracker.owner[s]);
  endtask

  task automatic open_round();
    logic [ID_BITS-1:0] id;
    logic [PID_BITS-1:0] pid;
    repeat ($urandom_range(4, 18)) send(ACT_OPEN, pick_id(), pick_pid());
    repeat ($urandom_range(2, 8)) begin
      id = pick_id();
      pid = pick_pid();
      if (id_in_range(id) && tracker.is_open[id-1] && $urandom_range(0, 4) != 0)
        pid = tracker.owner[id-1];
      send(ACT_CLOSE, id, pid);
    end
  endtask

  initial begin
    int a;
    int i;
    int r;
    int target;
    int rounds;
    round_mode_e mode;
    logic [PID_BITS-1:0] pa;
    logic [PID_BITS-1:0] pb;
    pid_pool[0] = '0;
    pid_pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) pid_pool[i] = PID_BITS'($urandom);
    pa = {PID_BITS/2{2'b10}};
    pb = {PID_BITS/2{2'b01}};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words
    send(ACT_OPEN, ID_BITS'(ID_TOP), '1);
    send(ACT_OPEN, '0, '0);
    send(ACT_CLOSE, 5'd1, '0);             // not the owner
    send(ACT_CLOSE, 5'd1, '1);
    send(ACT_OPEN, '0, pb);                // reuses the lowest closed slot
    send(ACT_LOCK, 5'd1, pa);
    send(ACT_LOCK, 5'd1, pa);              // holder gets queued too
    send(ACT_LOCK, 5'd1, '1);
    send(ACT_CHECK, 5'd1, '1);
    send(ACT_CHECK, 5'd1, '0);
    send(ACT_CLOSE, 5'd1, pb);             // locked
    send(ACT_UNLOCK, 5'd1, '0);
    send(ACT_UNLOCK, 5'd1, '0);
    send(ACT_UNLOCK, 5'd1, pa);
    send(ACT_UNLOCK, 5'd1, pa);            // no longer locked
    send(ACT_LOCK, ID_BITS'(MAX_SLOTS), pa);   // never created
    send(ACT_CLOSE, ID_BITS'(MAX_SLOTS), pa);
    send(ACT_CHECK, ID_BITS'(MAX_SLOTS), pa);
    for (a = int'(ACT_UNLOCK) + 1; a <= ACTION_TOP; a++) send(ACTION_BITS'(a), 5'd1, pb);
    send(ACT_LOCK, '0, pa);
    send(ACT_UNLOCK, ID_BITS'(MAX_SLOTS + 1), pa);
    send(ACT_CHECK, ID_BITS'(ID_TOP), pa);
    send(ACT_CLOSE, 5'd2, '0);
    send(ACT_CHECK, 5'd2, '0);             // closed slot answers from its queue
    drain_results();

    target = items_sent + RANDOM_ITEMS;
    rounds = 0;
    while (items_sent < target) begin
      r = $urandom_range(0, 9);
      if (rounds == 0) mode = BACKPRESSURE;
      else if (r < 5) mode = MIX;
      else if (r < 7) mode = QUEUE_FILL;
      else if (r < 8) mode = OPEN_BURST;
      else if (r < 9) mode = DRAIN_MIX;
      else mode = BACKPRESSURE;
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      case (mode)
        MIX:        mix_round(20);
        QUEUE_FILL: queue_round();
        OPEN_BURST: open_round();
        DRAIN_MIX: begin
          drain_results();
          mix_round(10);
        end
        default: begin
          // receiver holds off while words keep coming, so the input stalls
          hold_results = 1'b1;
          tx_fast = 1'b1;
          mix_round(12);
        end
      endcase
      rounds++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.owed_resp.size() != 0) tracker.report("result words still owed at end");
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> mutex_table_with_wait_queues.f
sv/mtq_pkg.sv
sv/mtq_slot_table.sv
sv/mtq_wait_queue.sv
sv/mutex_table_with_wait_queues.sv
verif/tb.sv
